[rtl/gdd_pkg.sv]
// Shared types, constants and calendar helpers for the Gregorian date difference block.
// No dependencies; imported by every module of the block.
package gdd_pkg;

    localparam int DAY_W  = 5;
    localparam int MON_W  = 4;
    localparam int YEAR_W = 14;
    localparam int DN_W   = 23;
    localparam int DIFF_W = 22;
    localparam int OFF_W  = 9;
    localparam int PROD_W = 26;
    localparam int Q_W    = 9;

    localparam int DIFF_FIELD_MAX = 4194303;

    // x / 25 == (x * 5243) >> 17 for x below 43690
    localparam logic [12:0] DIV25_K = 13'd5243;
    localparam int          DIV25_S = 17;

    localparam logic signed [1:0] ORD_LATER   = 2'sb01;
    localparam logic signed [1:0] ORD_EARLIER = 2'sb11;
    localparam logic signed [1:0] ORD_EQUAL   = 2'sb00;

    localparam logic [MON_W-1:0] MON_JAN = 4'd1;
    localparam logic [MON_W-1:0] MON_FEB = 4'd2;
    localparam logic [MON_W-1:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } gdd_en_t;

    function automatic logic [OFF_W-1:0] days_before_month(input logic [MON_W-1:0] m);
        logic [OFF_W-1:0] r;
        case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_length(input logic [MON_W-1:0] m,
                                                      input logic leap);
        logic [DAY_W-1:0] r;
        case (m)
            4'd2:                r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9,
            4'd11:               r = 5'd30;
            default:             r = 5'd31;
        endcase
        return r;
    endfunction

    function automatic int leap_count(input int y);
        return (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
    endfunction

    // span from 1 Jan of year 1 to 31 Dec of max_year, clamped to the field
    function automatic int diff_cap(input int max_year);
        int span;
        span = 365 * (max_year + 1) + leap_count(max_year + 1) - 367;
        if (span > DIFF_FIELD_MAX)
            span = DIFF_FIELD_MAX;
        return span;
    endfunction

endpackage

[rtl/gregorian_date_difference.sv]
// Gregorian date difference: checks two dates, orders them and counts the days between.
// Four-stage pipeline, one item per cycle unless m_ready holds it off; m_valid rises when the
// accepted item reaches the stage-4 registers, after passing stages 1, 2 and 3.
// Each stage holds its own valid bit and stalls only when the stage after it is full, so
// bubbles close up under back-pressure; the stage-1 multipliers (divide by 25) set the depth.
// Depends on gdd_pkg, gdd_day_number and gdd_diff.
module gregorian_date_difference #(
    parameter int MAX_YEAR = 9999
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [gdd_pkg::DAY_W-1:0]     s_day_a,
    input  logic [gdd_pkg::MON_W-1:0]     s_month_a,
    input  logic [gdd_pkg::YEAR_W-1:0]    s_year_a,
    input  logic [gdd_pkg::DAY_W-1:0]     s_day_b,
    input  logic [gdd_pkg::MON_W-1:0]     s_month_b,
    input  logic [gdd_pkg::YEAR_W-1:0]    s_year_b,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_valid_a,
    output logic                          m_valid_b,
    output logic signed [1:0]             m_order,
    output logic [gdd_pkg::DIFF_W-1:0]    m_day_difference,
    output logic                          m_month_error
);
    import gdd_pkg::*;

    localparam logic [DN_W-1:0] DIFF_CAP = DN_W'(diff_cap(MAX_YEAR));

    logic [4:1] vld_reg, vld_next;
    logic [4:1] rdy;
    gdd_en_t    en;

    always_comb begin
        rdy[4]   = !vld_reg[4] || m_ready;
        rdy[3]   = !vld_reg[3] || rdy[4];
        rdy[2]   = !vld_reg[2] || rdy[3];
        rdy[1]   = !vld_reg[1] || rdy[2];
        en.s1    = rdy[1];
        en.s2    = rdy[2];
        en.s3    = rdy[3];
        en.s4    = rdy[4];
        vld_next = vld_reg;
        if (rdy[1]) vld_next[1] = s_valid;
        if (rdy[2]) vld_next[2] = vld_reg[1];
        if (rdy[3]) vld_next[3] = vld_reg[2];
        if (rdy[4]) vld_next[4] = vld_reg[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_ready = rdy[1];
    assign m_valid = vld_reg[4];

    // order and month error ride alongside the day-number pipes
    logic signed [1:0] ord_next;
    logic              merr_next;
    logic signed [1:0] ord1_reg, ord2_reg, ord3_reg, ord4_reg;
    logic              merr1_reg, merr2_reg, merr3_reg, merr4_reg;
    logic              ok4a_reg, ok4b_reg;

    always_comb begin
        if (s_year_a != s_year_b)
            ord_next = (s_year_a > s_year_b) ? ORD_LATER : ORD_EARLIER;
        else if (s_month_a != s_month_b)
            ord_next = (s_month_a > s_month_b) ? ORD_LATER : ORD_EARLIER;
        else if (s_day_a != s_day_b)
            ord_next = (s_day_a > s_day_b) ? ORD_LATER : ORD_EARLIER;
        else
            ord_next = ORD_EQUAL;
        merr_next = !(s_month_a inside {[MON_JAN:MON_DEC]})
                 || !(s_month_b inside {[MON_JAN:MON_DEC]});
    end

    logic [DN_W-1:0] num_a, num_b;
    logic            ok_a, ok_b;

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            ord1_reg  <= ord_next;
            merr1_reg <= merr_next;
        end
        if (en.s2) begin
            ord2_reg  <= ord1_reg;
            merr2_reg <= merr1_reg;
        end
        if (en.s3) begin
            ord3_reg  <= ord2_reg;
            merr3_reg <= merr2_reg;
        end
        if (en.s4) begin
            ord4_reg  <= ord3_reg;
            merr4_reg <= merr3_reg;
            ok4a_reg  <= ok_a;
            ok4b_reg  <= ok_b;
        end
    end

    gdd_day_number u_dn_a (
        .aclk    (aclk),
        .en      (en),
        .day     (s_day_a),
        .month   (s_month_a),
        .year    (s_year_a),
        .day_num (num_a),
        .date_ok (ok_a)
    );

    gdd_day_number u_dn_b (
        .aclk    (aclk),
        .en      (en),
        .day     (s_day_b),
        .month   (s_month_b),
        .year    (s_year_b),
        .day_num (num_b),
        .date_ok (ok_b)
    );

    gdd_diff #(
        .DIFF_CAP (DIFF_CAP)
    ) u_diff (
        .aclk           (aclk),
        .en             (en),
        .num_a          (num_a),
        .num_b          (num_b),
        .month_err      (merr3_reg),
        .day_difference (m_day_difference)
    );

    assign m_valid_a     = ok4a_reg;
    assign m_valid_b     = ok4b_reg;
    assign m_order       = ord4_reg;
    assign m_month_error = merr4_reg;

`ifndef SYNTHESIS
    a_merr_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_month_error |-> m_day_difference == '0)
        else $error("month error with nonzero difference");

    a_equal_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_order == ORD_EQUAL) |-> m_day_difference == '0)
        else $error("equal dates with nonzero difference");

    a_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> DN_W'(m_day_difference) <= DIFF_CAP)
        else $error("difference above saturation limit");

    a_order_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_order != 2'sb10)
        else $error("bad order code");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid && !m_ready && (vld_reg == 4'hF))
        else $error("input stalled with room in pipeline");
`endif

endmodule

[rtl/gdd_day_number.sv]
// Three-stage day number unit: day number since 1 Jan of year 0 and date validity.
// Depends on gdd_pkg.
module gdd_day_number (
    input  logic                        aclk,
    input  gdd_pkg::gdd_en_t            en,
    input  logic [gdd_pkg::DAY_W-1:0]   day,
    input  logic [gdd_pkg::MON_W-1:0]   month,
    input  logic [gdd_pkg::YEAR_W-1:0]  year,
    output logic [gdd_pkg::DN_W-1:0]    day_num,
    output logic                        date_ok
);
    import gdd_pkg::*;

    // stage 1
    logic [DAY_W-1:0]  d1_reg;
    logic [MON_W-1:0]  m1_reg;
    logic [YEAR_W-1:0] y1_reg;
    logic [PROD_W-1:0] prod_a_reg, prod_a_next;
    logic [PROD_W-1:0] prod_b_reg, prod_b_next;
    logic [PROD_W-1:0] prod_c_reg, prod_c_next;
    logic [14:0]       sum_b, sum_c;

    always_comb begin
        sum_b       = {1'b0, year} + 15'd99;
        sum_c       = {1'b0, year} + 15'd399;
        prod_a_next = PROD_W'({1'b0, year[13:2]}) * PROD_W'(DIV25_K);
        prod_b_next = PROD_W'(sum_b[14:2]) * PROD_W'(DIV25_K);
        prod_c_next = PROD_W'(sum_c[14:4]) * PROD_W'(DIV25_K);
    end

    always_ff @(posedge aclk) begin
        if (en.s1) begin
            d1_reg     <= day;
            m1_reg     <= month;
            y1_reg     <= year;
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            prod_c_reg <= prod_c_next;
        end
    end

    // stage 2
    logic [DN_W-1:0]  base_reg, base_next;
    logic [OFF_W-1:0] off_reg, off_next;
    logic             ok2_reg, ok2_next;
    logic [Q_W-1:0]   qa, qb, qc;
    logic [11:0]      qa25, ra;
    logic [14:0]      sum_4;
    logic [12:0]      leaps;
    logic             leap;
    logic [DAY_W-1:0] mlen;

    always_comb begin
        qa    = prod_a_reg[DIV25_S +: Q_W];
        qb    = prod_b_reg[DIV25_S +: Q_W];
        qc    = prod_c_reg[DIV25_S +: Q_W];
        qa25  = 12'(qa) * 12'd25;
        ra    = y1_reg[13:2] - qa25;
        leap  = (y1_reg[1:0] == 2'd0) && ((ra != 12'd0) || (y1_reg[3:2] == 2'd0));
        sum_4 = {1'b0, y1_reg} + 15'd3;
        leaps = sum_4[14:2] - 13'(qb) + 13'(qc);
        base_next = DN_W'(y1_reg) * DN_W'(365) + DN_W'(leaps);
        off_next  = days_before_month(m1_reg) + OFF_W'(d1_reg)
                  + OFF_W'((m1_reg > MON_FEB) && leap);
        mlen      = month_length(m1_reg, leap);
        ok2_next  = (y1_reg != '0) && (m1_reg inside {[MON_JAN:MON_DEC]})
                  && (d1_reg != '0) && (d1_reg <= mlen);
    end

    always_ff @(posedge aclk) begin
        if (en.s2) begin
            base_reg <= base_next;
            off_reg  <= off_next;
            ok2_reg  <= ok2_next;
        end
    end

    // stage 3
    logic [DN_W-1:0] dn_reg;
    logic            ok3_reg;

    always_ff @(posedge aclk) begin
        if (en.s3) begin
            dn_reg  <= base_reg + DN_W'(off_reg);
            ok3_reg <= ok2_reg;
        end
    end

    assign day_num = dn_reg;
    assign date_ok = ok3_reg;

endmodule

[rtl/gdd_diff.sv]
// Final stage: absolute day-number difference with saturation and month-error zeroing.
// Depends on gdd_pkg.
module gdd_diff #(
    parameter logic [gdd_pkg::DN_W-1:0] DIFF_CAP = 23'd3652058
) (
    input  logic                        aclk,
    input  gdd_pkg::gdd_en_t            en,
    input  logic [gdd_pkg::DN_W-1:0]    num_a,
    input  logic [gdd_pkg::DN_W-1:0]    num_b,
    input  logic                        month_err,
    output logic [gdd_pkg::DIFF_W-1:0]  day_difference
);
    import gdd_pkg::*;

    logic [DN_W-1:0]   mag, sat;
    logic [DIFF_W-1:0] diff_reg, diff_next;

    always_comb begin
        mag       = (num_a > num_b) ? (num_a - num_b) : (num_b - num_a);
        sat       = (mag > DIFF_CAP) ? DIFF_CAP : mag;
        diff_next = month_err ? '0 : sat[DIFF_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (en.s4) begin
            diff_reg <= diff_next;
        end
    end

    assign day_difference = diff_reg;

endmodule

[bench/gregorian_date_difference_tb.sv]
// Testbench for gregorian_date_difference: directed and random date pairs under random idling.
// A scoreboard class predicts each result; plain tasks drive the item channel and an initial block the result channel.
// Depends on gdd_pkg and the gregorian_date_difference RTL.
`timescale 1ns / 100ps

module gregorian_date_difference_tb;
    import gdd_pkg::*;

    localparam int MAX_YEAR    = 9999;
    localparam int WATCH_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;
    localparam int RAND_ITEMS  = 400;

    typedef struct {
        logic                    valid_a;
        logic                    valid_b;
        logic signed [1:0]       order;
        logic [DIFF_W-1:0]       diff;
        logic                    month_error;
    } date_span_t;

    class date_span_board;
        date_span_t     due[$];
        int unsigned    fails;
        longint         span_cap;

        function new();
            fails    = 0;
            span_cap = day_index(31, 12, MAX_YEAR) - day_index(1, 1, 1);
            if (span_cap > DIFF_FIELD_MAX)
                span_cap = DIFF_FIELD_MAX;
        endfunction

        function bit leap_year(longint y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int month_days(int m, longint y);
            case (m)
                2:              return leap_year(y) ? 29 : 28;
                4, 6, 9, 11:    return 30;
                default:        return 31;
            endcase
        endfunction

        function int month_offset(int m);
            case (m)
                2:       return 31;
                3:       return 59;
                4:       return 90;
                5:       return 120;
                6:       return 151;
                7:       return 181;
                8:       return 212;
                9:       return 243;
                10:      return 273;
                11:      return 304;
                12:      return 334;
                default: return 0;
            endcase
        endfunction

        // days since the start of proleptic year 0
        function longint day_index(longint d, int m, longint y);
            longint n;
            n = 365 * y + (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400 + month_offset(m) + d;
            if (m > 2 && leap_year(y))
                n++;
            return n;
        endfunction

        function bit real_date(int d, int m, int y);
            if (y < 1 || m < 1 || m > 12)
                return 1'b0;
            return d >= 1 && d <= month_days(m, y);
        endfunction

        function void note_dates(int da, int ma, int ya, int db, int mb, int yb);
            date_span_t r;
            longint     na, nb, span;
            r.valid_a     = real_date(da, ma, ya);
            r.valid_b     = real_date(db, mb, yb);
            r.month_error = 1'b0;
            r.diff        = '0;
            if (ya != yb)
                r.order = (ya > yb) ? ORD_LATER : ORD_EARLIER;
            else if (ma != mb)
                r.order = (ma > mb) ? ORD_LATER : ORD_EARLIER;
            else if (da != db)
                r.order = (da > db) ? ORD_LATER : ORD_EARLIER;
            else
                r.order = ORD_EQUAL;
            if (ma < 1 || ma > 12 || mb < 1 || mb > 12) begin
                r.month_error = 1'b1;
            end else begin
                na   = day_index(da, ma, ya);
                nb   = day_index(db, mb, yb);
                span = (na > nb) ? na - nb : nb - na;
                if (span > span_cap)
                    span = span_cap;
                r.diff = span[DIFF_W-1:0];
            end
            due.push_back(r);
        endfunction

        function void compare(string what, longint want, longint got);
            if (want != got) begin
                fails++;
                $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
            end
        endfunction

        function void check_result(logic va, logic vb, logic signed [1:0] ord,
                                   logic [DIFF_W-1:0] diff, logic merr);
            date_span_t r;
            if (due.size() == 0) begin
                fails++;
                $display("%0t: unexpected result expected none actual order %0d diff %0d",
                         $time, ord, diff);
                return;
            end
            r = due.pop_front();
            compare("valid_a", r.valid_a, va);
            compare("valid_b", r.valid_b, vb);
            compare("order", longint'(r.order), longint'(ord));
            compare("day_difference", r.diff, diff);
            compare("month_error", r.month_error, merr);
        endfunction

        function int pending();
            return due.size();
        endfunction
    endclass

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    logic [DAY_W-1:0]       s_day_a;
    logic [MON_W-1:0]       s_month_a;
    logic [YEAR_W-1:0]      s_year_a;
    logic [DAY_W-1:0]       s_day_b;
    logic [MON_W-1:0]       s_month_b;
    logic [YEAR_W-1:0]      s_year_b;
    logic                   m_valid;
    logic                   m_ready;
    logic                   m_valid_a;
    logic                   m_valid_b;
    logic signed [1:0]      m_order;
    logic [DIFF_W-1:0]      m_day_difference;
    logic                   m_month_error;

    date_span_board board;
    bit             tx_burst;
    bit             hold_request;

    gregorian_date_difference #(
        .MAX_YEAR(MAX_YEAR)
    ) u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_day_a          (s_day_a),
        .s_month_a        (s_month_a),
        .s_year_a         (s_year_a),
        .s_day_b          (s_day_b),
        .s_month_b        (s_month_b),
        .s_year_b         (s_year_b),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_valid_a        (m_valid_a),
        .m_valid_b        (m_valid_b),
        .m_order          (m_order),
        .m_day_difference (m_day_difference),
        .m_month_error    (m_month_error)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                board.note_dates(s_day_a, s_month_a, s_year_a, s_day_b, s_month_b, s_year_b);
            if (m_valid && m_ready)
                board.check_result(m_valid_a, m_valid_b, m_order, m_day_difference,
                                   m_month_error);
        end
    end

    initial begin
        int idle;
        idle = 0;
        while (idle < WATCH_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle = 0;
            else
                idle++;
        end
        $display("gregorian_date_difference_tb NOT OK");
        $finish;
    end

    // result side: random stalls, calm stretches, and one long hold-off on request
    initial begin
        int  wait_cycles;
        int  taken;
        bit  calm;
        m_ready <= 1'b0;
        taken = 0;
        calm  = 1'b0;
        while (!aresetn)
            @(posedge aclk);
        forever begin
            if (taken % 40 == 0)
                calm = ($urandom_range(0, 2) == 0);
            if (hold_request) begin
                hold_request = 1'b0;
                wait_cycles  = HOLD_CYCLES;
            end else begin
                wait_cycles = calm ? 0 : $urandom_range(0, 17);
            end
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    task automatic send_dates(input logic [DAY_W-1:0] da, input logic [MON_W-1:0] ma,
                              input logic [YEAR_W-1:0] ya, input logic [DAY_W-1:0] db,
                              input logic [MON_W-1:0] mb, input logic [YEAR_W-1:0] yb);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_day_a   <= da;
        s_month_a <= ma;
        s_year_a  <= ya;
        s_day_b   <= db;
        s_month_b <= mb;
        s_year_b  <= yb;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge aclk);
    endtask

    task automatic pick_date(output logic [DAY_W-1:0] d, output logic [MON_W-1:0] m,
                             output logic [YEAR_W-1:0] y);
        int edge_years[10] = '{0, 1, 4, 100, 400, 1900, 2000, 9999, 10000, 16383};
        int edge_months[7] = '{0, 1, 2, 3, 12, 13, 15};
        int edge_days[6]   = '{0, 1, 28, 29, 30, 31};
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            y = YEAR_W'($urandom_range(1, MAX_YEAR));
            m = MON_W'($urandom_range(1, 12));
            d = DAY_W'($urandom_range(1, board.month_days(m, y)));
        end else if (pick < 85) begin
            y = YEAR_W'($urandom_range(0, 16383));
            m = MON_W'($urandom_range(0, 15));
            d = DAY_W'($urandom_range(0, 31));
        end else begin
            y = YEAR_W'(edge_years[$urandom_range(0, 9)]);
            m = MON_W'(edge_months[$urandom_range(0, 6)]);
            d = DAY_W'(edge_days[$urandom_range(0, 5)]);
        end
    endtask

    initial begin
        logic [DAY_W-1:0]  da, db;
        logic [MON_W-1:0]  ma, mb;
        logic [YEAR_W-1:0] ya, yb;
        int                pick;
        board        = new();
        tx_burst     = 1'b0;
        hold_request = 1'b0;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_day_a   <= '0;
        s_month_a <= '0;
        s_year_a  <= '0;
        s_day_b   <= '0;
        s_month_b <= '0;
        s_year_b  <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        send_dates(5'd1, MON_JAN, 14'd1, 5'd1, MON_JAN, 14'd1);
        send_dates(5'd31, MON_DEC, 14'd9999, 5'd1, MON_JAN, 14'd1);
        send_dates(5'd1, MON_JAN, 14'd1, 5'd31, MON_DEC, 14'd9999);
        send_dates(5'd31, 4'd15, 14'd16383, 5'd0, 4'd0, 14'd0);
        send_dates(5'd31, MON_DEC, 14'd16383, 5'd0, MON_JAN, 14'd0);
        send_dates(5'd29, MON_FEB, 14'd2000, 5'd29, MON_FEB, 14'd1900);
        send_dates(5'd29, MON_FEB, 14'd2004, 5'd29, MON_FEB, 14'd2023);
        send_dates(5'd28, MON_FEB, 14'd2100, 5'd1, 4'd3, 14'd2100);
        send_dates(5'd1, 4'd0, 14'd2020, 5'd1, 4'd5, 14'd2020);
        send_dates(5'd1, 4'd6, 14'd2020, 5'd1, 4'd13, 14'd2020);
        send_dates(5'd15, 4'd15, 14'd500, 5'd15, 4'd15, 14'd500);
        send_dates(5'd0, 4'd7, 14'd1999, 5'd30, 4'd6, 14'd1999);
        send_dates(5'd31, 4'd4, 14'd2010, 5'd1, 4'd5, 14'd2010);
        send_dates(5'd31, MON_FEB, 14'd2001, 5'd1, 4'd3, 14'd2001);
        send_dates(5'd1, MON_JAN, 14'd0, 5'd31, MON_DEC, 14'd0);
        send_dates(5'd31, MON_DEC, 14'd10000, 5'd1, MON_JAN, 14'd9999);
        send_dates(5'd29, MON_FEB, 14'd400, 5'd1, 4'd3, 14'd400);
        send_dates(5'd10, 4'd11, 14'd8191, 5'd20, 4'd9, 14'd8192);
        send_dates(5'd16, 4'd8, 14'd5461, 5'd15, 4'd7, 14'd10922);
        send_dates(5'd1, MON_JAN, 14'd1, 5'd1, MON_JAN, 14'd2);
        drain();

        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 30 == 0)
                tx_burst = ($urandom_range(0, 2) == 0);
            if (i == 150) begin
                hold_request = 1'b1;
                tx_burst     = 1'b1;
            end
            if (i == 180)
                tx_burst = 1'b0;
            if (i == 260)
                drain();
            pick_date(da, ma, ya);
            pick = $urandom_range(0, 9);
            if (pick < 2) begin
                {db, mb, yb} = {da, ma, ya};
            end else if (pick < 4) begin
                {mb, yb} = {ma, ya};
                db = DAY_W'($urandom_range(0, 31));
            end else begin
                pick_date(db, mb, yb);
            end
            send_dates(da, ma, ya, db, mb, yb);
        end

        drain();
        repeat (10) @(posedge aclk);
        if (board.fails == 0)
            $display("gregorian_date_difference_tb OK");
        else
            $display("gregorian_date_difference_tb NOT OK");
        $finish;
    end

endmodule

[filelist.f]
rtl/gdd_pkg.sv
rtl/gdd_day_number.sv
rtl/gdd_diff.sv
rtl/gregorian_date_difference.sv
bench/gregorian_date_difference_tb.sv
